### design/cpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_pkg
// Shared types, constants and helpers for the polygon slide collision block.
// ----------------------------------------------------------------------------
package cpsc_pkg;

   localparam int MAX_EDGES_DEF    = 16;
   localparam int POLY_ID_BITS_DEF = 16;
   localparam int CSR_W            = 5;
   localparam logic [CSR_W-1:0] CSR_RESET = 5'd3;
   localparam int MIN_EDGES        = 3;
   localparam int EDGE_INDEX_W     = 4;

   // 0.0001 in Q16.16 and in Q32.32
   localparam logic signed [63:0] TOL_Q16 = 64'sd7;
   localparam logic signed [63:0] TOL_Q32 = 64'sd429497;

   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 33;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WR_MUL0,
      ST_WR_MUL1,
      ST_WR_STORE,
      ST_RD_ENTRY,
      ST_RD_NEXTV,
      ST_RD_DONE,
      ST_CR_CHK,
      ST_EP_MUL0,
      ST_EP_MUL1,
      ST_SP_MUL0,
      ST_SP_MUL1,
      ST_EVAL,
      ST_DIV,
      ST_CX_MUL,
      ST_CY_MUL,
      ST_CY_DONE,
      ST_OX_MUL,
      ST_OY_MUL,
      ST_ON_CHK,
      ST_SN_MUL0,
      ST_SN_MUL1,
      ST_SN_SINK,
      ST_SN_PX,
      ST_SN_PY,
      ST_SN_DONE,
      ST_EMIT
   } cpsc_state_type;

   typedef enum logic [1:0] {
      DIR_NONE,
      DIR_FWD,
      DIR_BACK
   } edge_dir_type;

   function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // position of p along edge a->b: behind a, beyond b, or between
   function automatic edge_dir_type edge_dir(
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] ax, input logic signed [31:0] ay,
      input logic signed [31:0] bx, input logic signed [31:0] by);
      logic signed [63:0] d;
      logic signed [31:0] pc, ac, bc;
      edge_dir_type r;
      d  = sext32(ax) - sext32(bx);
      pc = px;
      ac = ax;
      bc = bx;
      if (d <= TOL_Q16 && d >= -TOL_Q16) begin
         pc = py;
         ac = ay;
         bc = by;
      end
      if (ac > bc) begin
         if (pc >= ac) r = DIR_BACK;
         else if (pc <= bc) r = DIR_FWD;
         else r = DIR_NONE;
      end else begin
         if (pc <= ac) r = DIR_BACK;
         else if (pc >= bc) r = DIR_FWD;
         else r = DIR_NONE;
      end
      return r;
   endfunction

endpackage

### design/cpsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cpsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/cpsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpsc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cpsc_pkg::DIV_NUM_W-1:0] num,
   input  logic [cpsc_pkg::DIV_DEN_W-1:0] den,
   output logic                           done,
   output logic [cpsc_pkg::DIV_NUM_W-1:0] quo
);
   import cpsc_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### design/convex_polygon_slide_collision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_slide_collision
// Convex polygon edge table with move collision, link hand-off and wall slide.
// ----------------------------------------------------------------------------
//  channel | ports              | moves
//  req     | req_valid/stall    | edge write or move query word
//  rsp     | rsp_valid/stall    | one result word per query
//  csr     | csr_wr_en/wr_data  | edge_count
//
// Edge write: two products form the offset, then the entry is stored. A query
// reads and tests each edge scanned; a crossed edge adds the 48-step divide and
// the on-edge test, then the snap, any crawled edges and the emit follow; the
// single edge RAM read port and the one shared 32x32 multiplier set the pace.
// Reset is synchronous; edge entries are undefined until written.
// A finished result sits in the output register while the next word is taken.
module convex_polygon_slide_collision #(
   parameter int MAX_EDGES    = cpsc_pkg::MAX_EDGES_DEF,
   parameter int POLY_ID_BITS = cpsc_pkg::POLY_ID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [cpsc_pkg::EDGE_INDEX_W-1:0] req_edge_index,
   input  logic signed [31:0]               req_coord_a_x,
   input  logic signed [31:0]               req_coord_a_y,
   input  logic signed [31:0]               req_coord_b_x,
   input  logic signed [31:0]               req_coord_b_y,
   input  logic                             req_link_present,
   input  logic [POLY_ID_BITS-1:0]          req_link_id,
   input  logic                             req_scan_backward,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_complete,
   output logic signed [31:0]               rsp_final_x,
   output logic signed [31:0]               rsp_final_y,
   output logic [POLY_ID_BITS-1:0]          rsp_next_polygon,
   input  logic                             csr_wr_en,
   input  logic [cpsc_pkg::CSR_W-1:0]       csr_wr_data
);
   import cpsc_pkg::*;

   localparam int IW    = $clog2(MAX_EDGES);
   localparam int CW    = $clog2(MAX_EDGES + 1);
   localparam int NW    = ((CW > CSR_W) ? CW : CSR_W) + 1;
   localparam int ENT_W = 161 + POLY_ID_BITS;

   cpsc_state_type state_ff, state_in;

   logic [CSR_W-1:0] csr_ff;

   logic signed [31:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic                    wlink_ff, wlink_in, back_ff, back_in;
   logic [POLY_ID_BITS-1:0] wid_ff, wid_in;
   logic [EDGE_INDEX_W-1:0] widx_ff, widx_in;

   logic [CW-1:0] n_ff, n_in, s_ff, s_in, i_ff, i_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          crawl_ff, crawl_in, fwd_ff, fwd_in;

   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in, off_ff, off_in;
   logic signed [31:0] vxk_ff, vxk_in, vyk_ff, vyk_in, vx2_ff, vx2_in, vy2_ff, vy2_in;
   logic                    flag_ff, flag_in;
   logic [POLY_ID_BITS-1:0] tgt_ff, tgt_in;

   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] ep_ff, ep_in, ratio_ff, ratio_in, sink2_ff, sink2_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, px_ff, px_in;
   logic               okx_ff, okx_in, tneg_ff, tneg_in;

   logic                    res_cpl_ff, res_cpl_in;
   logic signed [31:0]      res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [POLY_ID_BITS-1:0] res_id_ff, res_id_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_cpl_ff, rsp_cpl_in;
   logic signed [31:0]      rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [POLY_ID_BITS-1:0] rsp_id_ff, rsp_id_in;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff, qp;

   logic             ram_we;
   logic [IW-1:0]    ram_waddr, ram_raddr;
   logic [ENT_W-1:0] ram_wdata, ram_rdata;

   logic                    div_start, div_done;
   logic [DIV_NUM_W-1:0]    div_num, div_quo;
   logic [DIV_DEN_W-1:0]    div_den;

   logic [NW-1:0]      cfg_ext;
   logic [CW-1:0]      idx_inc;
   logic [IW-1:0]      idx_fwd, idx_back, idx_step;
   logic signed [63:0] sink_w, travel_w, sum_w;
   logic signed [31:0] py_w, vsel_x, vsel_y;
   edge_dir_type       dir_w, want_dir;

   cpsc_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cpsc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign qp      = prod_ff >>> 16;
   assign sum_w   = acc_ff + qp;
   assign cfg_ext = NW'(csr_ff);
   assign idx_inc = CW'(idx_ff) + CW'(1);
   assign idx_fwd  = (idx_inc == n_ff) ? '0 : IW'(idx_inc);
   assign idx_back = (idx_ff == '0) ? IW'(n_ff - CW'(1)) : idx_ff - IW'(1);
   assign idx_step = fwd_ff ? idx_fwd : idx_back;
   assign sink_w   = sext32(ep_ff) - sext32(off_ff);
   assign travel_w = sext32(ep_ff) - sext32(sat32(sum_w));
   assign py_w     = sat32(sext32(by_ff) - qp);
   assign dir_w    = edge_dir(px_ff, py_w, vxk_ff, vyk_ff, vx2_ff, vy2_ff);
   assign want_dir = fwd_ff ? DIR_FWD : DIR_BACK;
   assign vsel_x   = fwd_ff ? vxk_ff : vx2_ff;
   assign vsel_y   = fwd_ff ? vyk_ff : vy2_ff;

   assign div_num = {sink_w[31:0], 16'h0000};
   assign div_den = travel_w[63] ? DIV_DEN_W'(-travel_w) : DIV_DEN_W'(travel_w);

   assign ram_waddr = IW'(widx_ff);
   assign ram_wdata = {wid_ff, wlink_ff, sat32(sum_w), by_ff, bx_ff, ay_ff, ax_ff};

   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff; by_in = by_ff;
      wlink_in = wlink_ff; back_in = back_ff; wid_in = wid_ff; widx_in = widx_ff;
      n_in = n_ff; s_in = s_ff; i_in = i_ff; idx_in = idx_ff;
      crawl_in = crawl_ff; fwd_in = fwd_ff;
      nx_in = nx_ff; ny_in = ny_ff; off_in = off_ff;
      vxk_in = vxk_ff; vyk_in = vyk_ff; vx2_in = vx2_ff; vy2_in = vy2_ff;
      flag_in = flag_ff; tgt_in = tgt_ff;
      acc_in = acc_ff; ep_in = ep_ff; ratio_in = ratio_ff; sink2_in = sink2_ff;
      cx_in = cx_ff; cy_in = cy_ff; px_in = px_ff; okx_in = okx_ff; tneg_in = tneg_ff;
      res_cpl_in = res_cpl_ff; res_x_in = res_x_ff; res_y_in = res_y_ff;
      res_id_in = res_id_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cpl_in = rsp_cpl_ff; rsp_x_in = rsp_x_ff; rsp_y_in = rsp_y_ff;
      rsp_id_in = rsp_id_ff;
      mul_a = '0;
      mul_b = '0;
      ram_we = 1'b0;
      ram_raddr = idx_ff;
      div_start = 1'b0;
      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ax_in = req_coord_a_x; ay_in = req_coord_a_y;
               bx_in = req_coord_b_x; by_in = req_coord_b_y;
               wlink_in = req_link_present;
               wid_in   = req_link_id;
               widx_in  = req_edge_index;
               back_in  = req_scan_backward;
               if (cfg_ext < NW'(MIN_EDGES)) n_in = CW'(MIN_EDGES);
               else if (cfg_ext > NW'(MAX_EDGES)) n_in = CW'(MAX_EDGES);
               else n_in = CW'(cfg_ext);
               s_in     = '0;
               crawl_in = 1'b0;
               idx_in   = req_scan_backward ? IW'(n_in - CW'(1)) : '0;
               state_in = (req_op == OP_WRITE) ? ST_WR_MUL0 : ST_RD_ENTRY;
            end
         end
         ST_WR_MUL0: begin
            mul_a = ax_ff; mul_b = bx_ff;
            state_in = ST_WR_MUL1;
         end
         ST_WR_MUL1: begin
            acc_in = qp;
            mul_a = ay_ff; mul_b = by_ff;
            state_in = ST_WR_STORE;
         end
         ST_WR_STORE: begin
            ram_we   = (32'(widx_ff) < 32'(MAX_EDGES));
            state_in = ST_IDLE;
         end
         ST_RD_ENTRY: begin
            state_in = ST_RD_NEXTV;
         end
         ST_RD_NEXTV: begin
            vxk_in  = ram_rdata[31:0];
            vyk_in  = ram_rdata[63:32];
            nx_in   = ram_rdata[95:64];
            ny_in   = ram_rdata[127:96];
            off_in  = ram_rdata[159:128];
            flag_in = ram_rdata[160];
            tgt_in  = ram_rdata[161 +: POLY_ID_BITS];
            ram_raddr = idx_fwd;
            state_in = ST_RD_DONE;
         end
         ST_RD_DONE: begin
            vx2_in = ram_rdata[31:0];
            vy2_in = ram_rdata[63:32];
            state_in = crawl_ff ? ST_CR_CHK : ST_EP_MUL0;
         end
         ST_CR_CHK: begin
            if (flag_ff) begin
               res_cpl_in = 1'b0; res_x_in = vsel_x; res_y_in = vsel_y;
               res_id_in = tgt_ff;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SN_MUL0;
            end
         end
         ST_EP_MUL0: begin
            mul_a = bx_ff; mul_b = nx_ff;
            state_in = ST_EP_MUL1;
         end
         ST_EP_MUL1: begin
            acc_in = qp;
            mul_a = by_ff; mul_b = ny_ff;
            state_in = ST_SP_MUL0;
         end
         ST_SP_MUL0: begin
            ep_in = sat32(sum_w);
            mul_a = ax_ff; mul_b = nx_ff;
            state_in = ST_SP_MUL1;
         end
         ST_SP_MUL1: begin
            acc_in = qp;
            mul_a = ay_ff; mul_b = ny_ff;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // edge skipped unless the end sinks past it with travel along normal
            if (sink_w <= 64'sd0 || travel_w == 64'sd0) begin
               if (s_ff == n_ff - CW'(1)) begin
                  res_cpl_in = 1'b1; res_x_in = bx_ff; res_y_in = by_ff;
                  res_id_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  s_in = s_ff + CW'(1);
                  idx_in = back_ff ? idx_ff - IW'(1) : idx_ff + IW'(1);
                  state_in = ST_RD_ENTRY;
               end
            end else begin
               div_start = 1'b1;
               tneg_in = travel_w[63];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (tneg_ff) begin
                  ratio_in = (div_quo > DIV_NUM_W'(64'h80000000)) ? 32'sh80000000
                                                                   : 32'(-div_quo);
               end else begin
                  ratio_in = (div_quo > DIV_NUM_W'(64'h7fffffff)) ? 32'sh7fffffff
                                                                   : 32'(div_quo);
               end
               state_in = ST_CX_MUL;
            end
         end
         ST_CX_MUL: begin
            mul_a = sat32(sext32(bx_ff) - sext32(ax_ff)); mul_b = ratio_ff;
            state_in = ST_CY_MUL;
         end
         ST_CY_MUL: begin
            cx_in = sat32(sext32(bx_ff) - qp);
            mul_a = sat32(sext32(by_ff) - sext32(ay_ff)); mul_b = ratio_ff;
            state_in = ST_CY_DONE;
         end
         ST_CY_DONE: begin
            cy_in = sat32(sext32(by_ff) - qp);
            state_in = ST_OX_MUL;
         end
         ST_OX_MUL: begin
            mul_a = sat32(sext32(cx_ff) - sext32(vxk_ff));
            mul_b = sat32(sext32(cx_ff) - sext32(vx2_ff));
            state_in = ST_OY_MUL;
         end
         ST_OY_MUL: begin
            okx_in = (vxk_ff == vx2_ff) || (prod_ff <= TOL_Q32);
            mul_a = sat32(sext32(cy_ff) - sext32(vyk_ff));
            mul_b = sat32(sext32(cy_ff) - sext32(vy2_ff));
            state_in = ST_ON_CHK;
         end
         ST_ON_CHK: begin
            if (!(okx_ff && ((vyk_ff == vy2_ff) || (prod_ff <= TOL_Q32)))) begin
               if (s_ff == n_ff - CW'(1)) begin
                  res_cpl_in = 1'b1; res_x_in = bx_ff; res_y_in = by_ff;
                  res_id_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  s_in = s_ff + CW'(1);
                  idx_in = back_ff ? idx_ff - IW'(1) : idx_ff + IW'(1);
                  state_in = ST_RD_ENTRY;
               end
            end else if (flag_ff) begin
               res_cpl_in = 1'b0; res_x_in = cx_ff; res_y_in = cy_ff;
               res_id_in = tgt_ff;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SN_MUL0;
            end
         end
         ST_SN_MUL0: begin
            mul_a = bx_ff; mul_b = nx_ff;
            state_in = ST_SN_MUL1;
         end
         ST_SN_MUL1: begin
            acc_in = qp;
            mul_a = by_ff; mul_b = ny_ff;
            state_in = ST_SN_SINK;
         end
         ST_SN_SINK: begin
            sink2_in = sat32(sext32(sat32(sum_w)) - sext32(off_ff));
            state_in = ST_SN_PX;
         end
         ST_SN_PX: begin
            mul_a = sink2_ff; mul_b = nx_ff;
            state_in = ST_SN_PY;
         end
         ST_SN_PY: begin
            px_in = sat32(sext32(bx_ff) - qp);
            mul_a = sink2_ff; mul_b = ny_ff;
            state_in = ST_SN_DONE;
         end
         ST_SN_DONE: begin
            if (!crawl_ff) begin
               if (dir_w == DIR_NONE) begin
                  res_cpl_in = 1'b1; res_x_in = px_ff; res_y_in = py_w;
                  res_id_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  crawl_in = 1'b1;
                  fwd_in   = (dir_w == DIR_FWD);
                  idx_in   = (dir_w == DIR_FWD) ? idx_fwd : idx_back;
                  i_in     = '0;
                  state_in = ST_RD_ENTRY;
               end
            end else if (dir_w != want_dir) begin
               res_cpl_in = 1'b1; res_x_in = vsel_x; res_y_in = vsel_y;
               res_id_in = '0;
               state_in = ST_EMIT;
            end else if (i_ff == n_ff - CW'(1)) begin
               // crawl cap reached: stop at the last snapped point
               res_cpl_in = 1'b1; res_x_in = px_ff; res_y_in = py_w;
               res_id_in = '0;
               state_in = ST_EMIT;
            end else begin
               i_in   = i_ff + CW'(1);
               idx_in = idx_step;
               state_in = ST_RD_ENTRY;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cpl_in = res_cpl_ff; rsp_x_in = res_x_ff; rsp_y_in = res_y_ff;
               rsp_id_in = res_id_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
         crawl_ff     <= 1'b0;
         fwd_ff       <= 1'b0;
         n_ff         <= CW'(MIN_EDGES);
         s_ff         <= '0;
         i_ff         <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         crawl_ff     <= crawl_in;
         fwd_ff       <= fwd_in;
         n_ff         <= n_in;
         s_ff         <= s_in;
         i_ff         <= i_in;
         idx_ff       <= idx_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
      prod_ff <= sext32(mul_a) * sext32(mul_b);
      ax_ff <= ax_in; ay_ff <= ay_in; bx_ff <= bx_in; by_ff <= by_in;
      wlink_ff <= wlink_in; back_ff <= back_in; wid_ff <= wid_in; widx_ff <= widx_in;
      nx_ff <= nx_in; ny_ff <= ny_in; off_ff <= off_in;
      vxk_ff <= vxk_in; vyk_ff <= vyk_in; vx2_ff <= vx2_in; vy2_ff <= vy2_in;
      flag_ff <= flag_in; tgt_ff <= tgt_in;
      acc_ff <= acc_in; ep_ff <= ep_in; ratio_ff <= ratio_in; sink2_ff <= sink2_in;
      cx_ff <= cx_in; cy_ff <= cy_in; px_ff <= px_in; okx_ff <= okx_in;
      tneg_ff <= tneg_in;
      res_cpl_ff <= res_cpl_in; res_x_ff <= res_x_in; res_y_ff <= res_y_in;
      res_id_ff <= res_id_in;
      rsp_cpl_ff <= rsp_cpl_in; rsp_x_ff <= rsp_x_in; rsp_y_ff <= rsp_y_in;
      rsp_id_ff <= rsp_id_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_complete     = rsp_cpl_ff;
   assign rsp_final_x      = rsp_x_ff;
   assign rsp_final_y      = rsp_y_ff;
   assign rsp_next_polygon = rsp_id_ff;

endmodule
